// ----- sv/window_stack_hit_test_unit_defines.svh -----
// assertion macros for the window stack hit test unit
`ifndef WINDOW_STACK_HIT_TEST_UNIT_DEFINES_SVH
`define WINDOW_STACK_HIT_TEST_UNIT_DEFINES_SVH

// same-cycle implication
`define WSHT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsht: same-cycle check failed");

// next-cycle implication
`define WSHT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsht: next-cycle check failed");

`endif

// ----- sv/wsht_pkg.sv -----
// types and codes for the window stack hit test unit
package wsht_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE,
    FUNC_RAISE,
    FUNC_HIT,
    FUNC_ROLE
  } func_t;

  localparam logic [1:0] CFG_WINDOW_COUNT  = 2'd0;
  localparam logic [1:0] CFG_FIRST_MOVABLE = 2'd1;
  localparam logic [1:0] CFG_DESKTOP_ROLE  = 2'd2;

  typedef struct packed {
    logic signed [15:0] left_edge;
    logic signed [15:0] top_edge;
    logic [14:0]        win_width;
    logic [14:0]        win_height;
    logic               visible_flag;
    logic [3:0]         role_code;
  } entry_t;

endpackage

// ----- sv/window_stack_hit_test_unit.sv -----
// window stack hit test unit: one stack memory walked one slot a cycle by a small sequencer
// write and early exits go straight to S_DONE; hit test and role search walk the slots in S_HIT
// or S_ROLE; raise walks them in S_RAISE, then puts the entry in S_PUT; a stalled output waits in S_DONE
// one item at a time: the next beat is taken once the result has entered the output register;
// one memory read and one write a cycle set the walk rate
// rst clears the sequencer, output valid and the three registers; stack entries are not cleared
`include "window_stack_hit_test_unit_defines.svh"

module window_stack_hit_test_unit
  import wsht_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [3:0]         slot,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [14:0]        width,
  input  logic [14:0]        height,
  input  logic               shown,
  input  logic [3:0]         role,
  input  logic               allow_desktop,
  input  logic signed [4:0]  fallback,
  input  logic [4:0]         scan_floor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [3:0]         found_slot,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data
);

  localparam int IW = $clog2(MAX_WINDOWS);
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT,
    S_ROLE,
    S_RAISE,
    S_PUT,
    S_DONE
  } state_t;

  state_t state;

  logic [4:0] window_count;
  logic [4:0] first_movable;
  logic [3:0] desktop_role;

  entry_t mem [MAX_WINDOWS];
  entry_t rd_data;
  entry_t temp;
  entry_t wd;
  logic          we;
  logic [IW-1:0] wa;

  logic [IW-1:0] ptr;
  logic [IW-1:0] chk;
  logic [IW-1:0] stop;
  logic          chk_vld;
  logic          head;

  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [3:0]         role_q;
  logic               incl_q;
  logic               fb_ok;
  logic [3:0]         fb_slot;

  logic       res_found;
  logic [3:0] res_slot;

  logic          accept;
  logic [NW-1:0] wc_ext;
  logic [NW-1:0] max_ext;
  logic [CW-1:0] used_n;
  logic [NW-1:0] n_ext;
  logic [NW-1:0] nm1;
  logic [NW-1:0] slot_ext;
  logic [NW-1:0] fm_ext;
  logic [NW-1:0] floor_ext;
  logic [NW-1:0] fb_ext;
  logic          slot_ok;

  logic signed [16:0] px17;
  logic signed [16:0] py17;
  logic signed [16:0] lx17;
  logic signed [16:0] ty17;
  logic signed [16:0] rx17;
  logic signed [16:0] by17;
  logic               hit_ok;
  logic               role_hit;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;

  assign wc_ext    = NW'(window_count);
  assign max_ext   = NW'(MAX_WINDOWS);
  assign used_n    = (wc_ext > max_ext) ? max_ext[CW-1:0] : wc_ext[CW-1:0];
  assign n_ext     = NW'(used_n);
  assign nm1       = n_ext - NW'(1);
  assign slot_ext  = NW'(slot);
  assign fm_ext    = NW'(first_movable);
  assign floor_ext = NW'(scan_floor);
  assign fb_ext    = NW'(fallback[3:0]);
  assign slot_ok   = slot_ext < max_ext;

  assign px17 = {px[15], px};
  assign py17 = {py[15], py};
  assign lx17 = {rd_data.left_edge[15], rd_data.left_edge};
  assign ty17 = {rd_data.top_edge[15], rd_data.top_edge};
  assign rx17 = lx17 + $signed({2'b00, rd_data.win_width});
  assign by17 = ty17 + $signed({2'b00, rd_data.win_height});

  assign hit_ok = rd_data.visible_flag
                  && (incl_q || (rd_data.role_code != desktop_role))
                  && (px17 >= lx17) && (px17 < rx17)
                  && (py17 >= ty17) && (py17 < by17);
  assign role_hit = (rd_data.role_code == role_q);

  always_comb begin
    we = 1'b0;
    wa = slot_ext[IW-1:0];
    wd = '{left_edge: pos_x, top_edge: pos_y, win_width: width, win_height: height,
           visible_flag: shown, role_code: role};
    case (state)
      S_IDLE: begin
        we = accept && (func_t'(func) == FUNC_WRITE) && slot_ok;
      end
      S_RAISE: begin
        we = chk_vld && !head;
        wa = chk - IW'(1);
        wd = rd_data;
      end
      S_PUT: begin
        we = 1'b1;
        wa = stop;
        wd = temp;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      chk_vld       <= 1'b0;
      head          <= 1'b0;
      window_count  <= '0;
      first_movable <= '0;
      desktop_role  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_COUNT:  window_count  <= cfg_data;
          CFG_FIRST_MOVABLE: first_movable <= cfg_data;
          CFG_DESKTOP_ROLE:  desktop_role  <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            px      <= pos_x;
            py      <= pos_y;
            role_q  <= role;
            incl_q  <= allow_desktop;
            fb_ok   <= !fallback[4] && (fb_ext < n_ext);
            fb_slot <= fallback[3:0];
            chk_vld <= 1'b0;
            head    <= 1'b1;
            case (func_t'(func))
              FUNC_WRITE: begin
                res_found <= slot_ok;
                res_slot  <= slot_ok ? slot : 4'd0;
                state     <= S_DONE;
              end
              FUNC_RAISE: begin
                if (slot_ext >= n_ext) begin
                  res_found <= 1'b0;
                  res_slot  <= 4'd0;
                  state     <= S_DONE;
                end else if ((slot_ext < fm_ext) || (slot_ext + NW'(1) >= n_ext)) begin
                  res_found <= 1'b1;
                  res_slot  <= slot;
                  state     <= S_DONE;
                end else begin
                  ptr   <= slot_ext[IW-1:0];
                  stop  <= nm1[IW-1:0];
                  state <= S_RAISE;
                end
              end
              FUNC_HIT: begin
                if (floor_ext >= n_ext) begin
                  res_found <= 1'b0;
                  res_slot  <= 4'd0;
                  state     <= S_DONE;
                end else begin
                  ptr   <= nm1[IW-1:0];
                  stop  <= floor_ext[IW-1:0];
                  state <= S_HIT;
                end
              end
              FUNC_ROLE: begin
                if (n_ext == '0) begin
                  res_found <= 1'b0;
                  res_slot  <= 4'd0;
                  state     <= S_DONE;
                end else begin
                  ptr   <= '0;
                  stop  <= nm1[IW-1:0];
                  state <= S_ROLE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_HIT: begin
          chk     <= ptr;
          chk_vld <= 1'b1;
          ptr     <= ptr - IW'(1);
          if (chk_vld) begin
            if (hit_ok) begin
              res_found <= 1'b1;
              res_slot  <= 4'(chk);
              state     <= S_DONE;
            end else if (chk == stop) begin
              res_found <= 1'b0;
              res_slot  <= 4'd0;
              state     <= S_DONE;
            end
          end
        end

        S_ROLE: begin
          chk     <= ptr;
          chk_vld <= 1'b1;
          ptr     <= ptr + IW'(1);
          if (chk_vld) begin
            if (role_hit) begin
              res_found <= 1'b1;
              res_slot  <= 4'(chk);
              state     <= S_DONE;
            end else if (chk == stop) begin
              res_found <= fb_ok;
              res_slot  <= fb_ok ? fb_slot : 4'd0;
              state     <= S_DONE;
            end
          end
        end

        S_RAISE: begin
          chk     <= ptr;
          chk_vld <= 1'b1;
          ptr     <= ptr + IW'(1);
          if (chk_vld) begin
            head <= 1'b0;
            if (head) begin
              temp <= rd_data;
            end
            if (chk == stop) begin
              state <= S_PUT;
            end
          end
        end

        S_PUT: begin
          res_found <= 1'b1;
          res_slot  <= 4'(stop);
          state     <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            found      <= res_found;
            found_slot <= res_slot;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WSHT_ASSERT_NXT(a_busy_after_beat, clk, rst, in_valid && !in_stall, in_stall)
  `WSHT_ASSERT_IMP(a_miss_slot_zero, clk, rst, out_valid && !found, found_slot == 4'd0)
  `WSHT_ASSERT_NXT(a_raise_to_put, clk, rst, (state == S_RAISE) && chk_vld && (chk == stop), state == S_PUT)
  `WSHT_ASSERT_IMP(a_put_after_walk, clk, rst, state == S_PUT, !head && chk_vld)

endmodule

// ----- dv/tb.sv -----
// testbench for window_stack_hit_test_unit: directed and random stack operations checked against a shadow stack
module tb;
  import wsht_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 165;

  typedef struct {
    func_t              func;
    logic [3:0]         slot;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [14:0]        w;
    logic [14:0]        h;
    logic               shown;
    logic [3:0]         role;
    logic               incl;
    logic signed [4:0]  fb;
    logic [4:0]         floor_slot;
  } cmd_t;

  typedef struct {
    logic       found;
    logic [3:0] slot;
  } reply_t;

  class stack_scoreboard;
    entry_t     stack_mem [16];
    logic [4:0] win_count;
    logic [4:0] first_movable;
    logic [3:0] desktop_role;
    reply_t     op_replies [$];
    int         errors;

    function new();
      win_count = '0;
      first_movable = '0;
      desktop_role = '0;
      errors = 0;
      foreach (stack_mem[i]) stack_mem[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] data);
      case (idx)
        CFG_WINDOW_COUNT: win_count = data;
        CFG_FIRST_MOVABLE: first_movable = data;
        CFG_DESKTOP_ROLE: desktop_role = data[3:0];
        default: ;
      endcase
    endfunction

    function reply_t stack_op_result(cmd_t c);
      reply_t r;
      entry_t e;
      int n, x, y, l, t, fbv;
      r.found = 1'b0;
      r.slot = '0;
      n = (win_count > 16) ? 16 : int'(win_count);
      case (c.func)
        FUNC_WRITE: begin
          stack_mem[c.slot].left_edge = c.px;
          stack_mem[c.slot].top_edge = c.py;
          stack_mem[c.slot].win_width = c.w;
          stack_mem[c.slot].win_height = c.h;
          stack_mem[c.slot].visible_flag = c.shown;
          stack_mem[c.slot].role_code = c.role;
          r.found = 1'b1;
          r.slot = c.slot;
        end
        FUNC_RAISE: begin
          if (int'(c.slot) < n) begin
            r.found = 1'b1;
            r.slot = c.slot;
            if (c.slot >= first_movable && int'(c.slot) + 1 < n) begin
              e = stack_mem[c.slot];
              for (int i = int'(c.slot); i + 1 < n; i++) stack_mem[i] = stack_mem[i + 1];
              stack_mem[n - 1] = e;
              r.slot = 4'(n - 1);
            end
          end
        end
        FUNC_HIT: begin
          x = c.px;
          y = c.py;
          for (int i = n; i > int'(c.floor_slot); i--) begin
            e = stack_mem[i - 1];
            l = $signed(e.left_edge);
            t = $signed(e.top_edge);
            if (e.visible_flag && (c.incl || e.role_code != desktop_role) &&
                x >= l && x < l + int'(e.win_width) &&
                y >= t && y < t + int'(e.win_height)) begin
              r.found = 1'b1;
              r.slot = 4'(i - 1);
              break;
            end
          end
        end
        default: begin
          for (int i = 0; i < n; i++) begin
            if (stack_mem[i].role_code == c.role) begin
              r.found = 1'b1;
              r.slot = 4'(i);
              break;
            end
          end
          fbv = c.fb;
          if (!r.found && fbv >= 0 && fbv < n) begin
            r.found = 1'b1;
            r.slot = 4'(fbv);
          end
        end
      endcase
      return r;
    endfunction

    function void take_cmd(cmd_t c);
      op_replies.push_back(stack_op_result(c));
    endfunction

    function void check_reply(logic f, logic [3:0] s);
      reply_t want;
      if (op_replies.size() == 0) begin
        $display("%0t: unexpected beat found=%b found_slot=%0d", $time, f, s);
        errors++;
        return;
      end
      want = op_replies.pop_front();
      if (f !== want.found) begin
        $display("%0t: found expected %b actual %b", $time, want.found, f);
        errors++;
      end
      if (s !== want.slot) begin
        $display("%0t: found_slot expected %0d actual %0d", $time, want.slot, s);
        errors++;
      end
    endfunction

    function int pending();
      return op_replies.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = '0;
  logic [3:0]         slot = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [14:0]        width = '0;
  logic [14:0]        height = '0;
  logic               shown = 1'b0;
  logic [3:0]         role = '0;
  logic               allow_desktop = 1'b0;
  logic signed [4:0]  fallback = '0;
  logic [4:0]         scan_floor = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found;
  logic [3:0]         found_slot;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [4:0]         cfg_data = '0;

  stack_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  int              cycle_cnt = 0;
  cmd_t            seen;
  int              cnt_tab [PHASES] = '{16, 0, 1, 2, 16, 8, 15, 16, 5, 12};
  int              mov_tab [PHASES] = '{4, 16, 0, 1, 0, 3, 15, 16, 2, 8};
  int              dsk_tab [PHASES] = '{1, 15, 0, 2, 3, 1, 0, 2, 3, 15};

  window_stack_hit_test_unit dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= gaps_on && ($urandom_range(99) < 13);

  always @(posedge clk) begin
    if (!rst && in_valid && in_stall === 1'b0) begin
      seen.func = func_t'(func);
      seen.slot = slot;
      seen.px = pos_x;
      seen.py = pos_y;
      seen.w = width;
      seen.h = height;
      seen.shown = shown;
      seen.role = role;
      seen.incl = allow_desktop;
      seen.fb = fallback;
      seen.floor_slot = scan_floor;
      sb.take_cmd(seen);
    end
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_reply(found, found_slot);
  end

  function automatic cmd_t mk_cmd(func_t f, int s, int x, int y, int w, int h, bit vis,
                                  int r, bit inc, int fb, int fl);
    cmd_t c;
    c.func = f;
    c.slot = 4'(s);
    c.px = 16'(x);
    c.py = 16'(y);
    c.w = 15'(w);
    c.h = 15'(h);
    c.shown = vis;
    c.role = 4'(r);
    c.incl = inc;
    c.fb = 5'(fb);
    c.floor_slot = 5'(fl);
    return c;
  endfunction

  function automatic int rim_offset(logic [14:0] len);
    case ($urandom_range(4))
      0: return -1;
      1: return 0;
      2: return int'(len) - 1;
      3: return int'(len);
      default: return int'($urandom_range(len));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    entry_t e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) c.func = FUNC_WRITE;
    else if (pick < 45) c.func = FUNC_RAISE;
    else if (pick < 80) c.func = FUNC_HIT;
    else c.func = FUNC_ROLE;
    c.slot = 4'($urandom_range(15));
    c.shown = ($urandom_range(9) != 0);
    c.role = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    c.incl = 1'($urandom_range(1));
    c.fb = 5'($urandom_range(16) - 1);
    c.floor_slot = ($urandom_range(3) == 0) ? 5'($urandom_range(16)) : 5'($urandom_range(3));
    if ($urandom_range(7) == 0) begin
      c.px = 16'($urandom());
      c.py = 16'($urandom());
      c.w = 15'($urandom());
      c.h = 15'($urandom());
    end else if (c.func == FUNC_WRITE) begin
      c.px = 16'(int'($urandom_range(400)) - 200);
      c.py = 16'(int'($urandom_range(400)) - 200);
      c.w = ($urandom_range(15) == 0) ? 15'd0 : 15'($urandom_range(300));
      c.h = ($urandom_range(15) == 0) ? 15'd0 : 15'($urandom_range(300));
    end else begin
      c.px = 16'(int'($urandom_range(800)) - 250);
      c.py = 16'(int'($urandom_range(800)) - 250);
      c.w = 15'($urandom_range(300));
      c.h = 15'($urandom_range(300));
    end
    if (c.func == FUNC_HIT && $urandom_range(1) == 1) begin
      e = sb.stack_mem[$urandom_range(15)];
      c.px = 16'(int'($signed(e.left_edge)) + rim_offset(e.win_width));
      c.py = 16'(int'($signed(e.top_edge)) + rim_offset(e.win_height));
    end
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= c.func;
    slot <= c.slot;
    pos_x <= c.px;
    pos_y <= c.py;
    width <= c.w;
    height <= c.h;
    shown <= c.shown;
    role <= c.role;
    allow_desktop <= c.incl;
    fallback <= c.fb;
    scan_floor <= c.floor_slot;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(int cnt, int mov, int dsk);
    write_reg(CFG_WINDOW_COUNT, 5'(cnt));
    write_reg(CFG_FIRST_MOVABLE, 5'(mov));
    write_reg(CFG_DESKTOP_ROLE, 5'(dsk));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cmd_t c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack: nothing to raise, role search falls through
    send_cmd(mk_cmd(FUNC_RAISE, 0, 0, 0, 0, 0, 0, 0, 0, -1, 0));
    send_cmd(mk_cmd(FUNC_ROLE, 15, -1, -1, 32767, 32767, 1, 5, 1, 0, 16));
    for (int i = 0; i < 16; i++) begin
      case (i)
        0: c = mk_cmd(FUNC_WRITE, i, -32768, -32768, 32767, 32767, 1, 0, 0, 0, 0);
        1: c = mk_cmd(FUNC_WRITE, i, -32768, -32768, 32767, 32767, 0, 7, 0, 0, 0);
        2: c = mk_cmd(FUNC_WRITE, i, 0, 0, 0, 100, 1, 1, 0, 0, 0);
        15: c = mk_cmd(FUNC_WRITE, i, 32767, 32767, 32767, 32767, 1, 15, 0, 0, 0);
        default: c = mk_cmd(FUNC_WRITE, i, i * 40 - 300, i * 30 - 200, 60 + i * 5, 45, 1,
                            i % 4, 0, 0, 0);
      endcase
      send_cmd(c);
    end
    drain();
    set_regs(16, 0, 0);
    send_cmd(mk_cmd(FUNC_HIT, 0, 32767, 32767, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_HIT, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_HIT, 0, -32768, -32768, 0, 0, 0, 0, 1, 0, 0));
    send_cmd(mk_cmd(FUNC_HIT, 0, 32767, 32767, 0, 0, 0, 0, 1, 0, 16));
    send_cmd(mk_cmd(FUNC_HIT, 0, 99, 54, 0, 0, 0, 0, 0, 0, 3));
    send_cmd(mk_cmd(FUNC_RAISE, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_RAISE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_ROLE, 0, 0, 0, 0, 0, 0, 15, 0, -1, 0));
    send_cmd(mk_cmd(FUNC_ROLE, 0, 0, 0, 0, 0, 0, 9, 0, 15, 0));
    send_cmd(mk_cmd(FUNC_ROLE, 0, 0, 0, 0, 0, 0, 9, 0, -1, 0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_regs(cnt_tab[p], mov_tab[p], dsk_tab[p]);
      gaps_on = (p != 4);
      for (int k = 0; k < PHASE_ITEMS; k++) send_cmd(rand_cmd());
      drain();
    end
    gaps_on = 1'b1;
    repeat (25) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
